[src/ps2mpt_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2mpt_pkg: shared types, constants and helpers
// Widths, CSR indexes, button attribute constants and the delta / clamp math
// used by the PS/2 mouse packet tracker.
// -----------------------------------------------------------------------------
package ps2mpt_pkg;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int COORD_W    = 16;   // width of reported coordinates
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int ATTR_W     = 8;

   // Held position width
   localparam int POS_BITS = 16;

   // Signed width wide enough for position plus/minus a scaled delta
   localparam int SUM_W = ((POS_BITS > CSR_DATA_W) ? POS_BITS : CSR_DATA_W) + 2;

   // Scaled delta: magnitude up to 256 / 6, signed
   localparam int DELTA_W = 8;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = CSR_IDX_W'(1);

   // CSR reset values
   localparam logic [CSR_DATA_W-1:0] SCREEN_WIDTH_RST  = CSR_DATA_W'(80);
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RST = CSR_DATA_W'(25);

   // Status byte bit positions
   localparam int ST_LEFT   = 0;
   localparam int ST_RIGHT  = 1;
   localparam int ST_MIDDLE = 2;
   localparam int ST_XSIGN  = 4;
   localparam int ST_YSIGN  = 5;

   // Cursor attribute constants
   localparam logic [ATTR_W-1:0] ATTR_BASE   = 8'hF0;
   localparam logic [ATTR_W-1:0] ATTR_LEFT   = 8'h10;
   localparam logic [ATTR_W-1:0] ATTR_RIGHT  = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_MIDDLE = 8'h30;

   // Reciprocal of 6 in 10 fractional bits; exact floor for magnitudes <= 256
   localparam int          RECIP_SHIFT = 10;
   localparam logic [17:0] RECIP6      = 18'd171;

   // Byte position within a packet
   typedef enum logic [1:0] {
      PH_STATUS = 2'd0,
      PH_DX     = 2'd1,
      PH_DY     = 2'd2
   } phase_type;

   // One assembled packet
   typedef struct packed {
      logic [BYTE_W-1:0] status;
      logic [BYTE_W-1:0] dx;
      logic [BYTE_W-1:0] dy;
   } pkt_type;

   // 9-bit two's complement delta (sign given apart), divided by 6 toward zero
   function automatic logic signed [DELTA_W-1:0] scale_delta(
      input logic [BYTE_W-1:0] low8,
      input logic              sign
   );
      logic [8:0]         mag;
      logic [17:0]        prod;
      logic [6:0]         quo;
      logic [DELTA_W-1:0] res;
      mag  = sign ? (9'd256 - {1'b0, low8}) : {1'b0, low8};
      prod = 18'(mag) * RECIP6;
      quo  = prod[RECIP_SHIFT+6:RECIP_SHIFT];
      res  = sign ? (8'd0 - {1'b0, quo}) : {1'b0, quo};
      return $signed(res);
   endfunction

   // Clamp a signed position to [0, size-1]; a size of zero pins it to 0
   function automatic logic [POS_BITS-1:0] clamp_axis(
      input logic signed [SUM_W-1:0]      v,
      input logic        [CSR_DATA_W-1:0] size
   );
      logic [POS_BITS-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v >= $signed(SUM_W'(size))) begin
         res = (size == '0) ? '0 : POS_BITS'(size - 16'd1);
      end else begin
         res = POS_BITS'(v);
      end
      return res;
   endfunction

endpackage

[src/ps2mpt_req_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2mpt_req_if: mouse byte channel
// Valid/ready channel carrying one received mouse byte per word.
// -----------------------------------------------------------------------------
interface ps2mpt_req_if;
   import ps2mpt_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/ps2mpt_rsp_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2mpt_rsp_if: cursor update channel
// Valid/ready channel carrying one cursor update word per mouse packet.
// -----------------------------------------------------------------------------
interface ps2mpt_rsp_if;
   import ps2mpt_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cursor_x;
   logic [COORD_W-1:0] cursor_y;
   logic [COORD_W-1:0] old_x;
   logic [COORD_W-1:0] old_y;
   logic               button_left;
   logic               button_right;
   logic               button_middle;
   logic [ATTR_W-1:0]  cursor_attr;

   modport source (
      output valid, output cursor_x, output cursor_y, output old_x, output old_y,
      output button_left, output button_right, output button_middle,
      output cursor_attr, input ready
   );
   modport sink (
      input valid, input cursor_x, input cursor_y, input old_x, input old_y,
      input button_left, input button_right, input button_middle,
      input cursor_attr, output ready
   );
endinterface

[src/ps2mpt_csr_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2mpt_csr_if: register write channel
// Valid/ready channel carrying a register index and write data.
// -----------------------------------------------------------------------------
interface ps2mpt_csr_if;
   import ps2mpt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/ps2mpt_assembler.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2mpt_assembler: packet framing
// Tracks the byte phase, holds status and X bytes, and registers a complete
// three-byte packet for the update stage.
// -----------------------------------------------------------------------------
module ps2mpt_assembler (
   input  logic                clock,
   input  logic                reset,
   ps2mpt_req_if.sink          req_ch,
   output logic                pkt_valid,
   output ps2mpt_pkg::pkt_type pkt,
   input  logic                pkt_ready
);
   import ps2mpt_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0] dx_ff, dx_in;
   logic              pkt_valid_ff, pkt_valid_in;
   pkt_type           pkt_ff, pkt_in;
   logic              accept;
   logic              load_status, load_dx, load_pkt;

   // Packet register frees up as soon as the update stage takes it
   assign req_ch.ready = !pkt_valid_ff || pkt_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_STATUS: phase_in = PH_DX;
            PH_DX:     phase_in = PH_DY;
            PH_DY:     phase_in = PH_STATUS;
            default:   phase_in = PH_DX;   // stray code acts as status byte
         endcase
      end
   end

   // Phase decode to load strobes
   always_comb begin
      load_status = 1'b0;
      load_dx     = 1'b0;
      load_pkt    = 1'b0;
      unique case (phase_ff)
         PH_DX:   load_dx     = accept;
         PH_DY:   load_pkt    = accept;
         default: load_status = accept;
      endcase
   end

   // Byte holding and packet register
   always_comb begin
      status_in    = load_status ? req_ch.rx_byte : status_ff;
      dx_in        = load_dx ? req_ch.rx_byte : dx_ff;
      pkt_valid_in = load_pkt || (pkt_valid_ff && !pkt_ready);
      pkt_in       = pkt_ff;
      if (load_pkt) begin
         pkt_in.status = status_ff;
         pkt_in.dx     = dx_ff;
         pkt_in.dy     = req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STATUS;
         status_ff    <= '0;
         dx_ff        <= '0;
         pkt_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         status_ff    <= status_in;
         dx_ff        <= dx_in;
         pkt_valid_ff <= pkt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign pkt_valid = pkt_valid_ff;
   assign pkt       = pkt_ff;

endmodule

[src/ps2mpt_update.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2mpt_update: position update and result register
// Scales the packet deltas, moves and clamps the held position, and registers
// the cursor update word.
// -----------------------------------------------------------------------------
module ps2mpt_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pkt_valid,
   input  ps2mpt_pkg::pkt_type                 pkt,
   output logic                                pkt_ready,
   input  logic [ps2mpt_pkg::CSR_DATA_W-1:0]   screen_width,
   input  logic [ps2mpt_pkg::CSR_DATA_W-1:0]   screen_height,
   ps2mpt_rsp_if.source                        rsp_ch
);
   import ps2mpt_pkg::*;

   logic [POS_BITS-1:0]       pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]       pos_y_ff, pos_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]        cur_x_ff, cur_y_ff, old_x_ff, old_y_ff;
   logic                      btn_l_ff, btn_r_ff, btn_m_ff;
   logic [ATTR_W-1:0]         attr_ff;
   logic                      take;
   logic signed [DELTA_W-1:0] dx_s, dy_s;
   logic signed [SUM_W-1:0]   sum_x, sum_y;
   logic                      btn_l, btn_r, btn_m;
   logic [ATTR_W-1:0]         attr;

   // Result register can take a new word while the old one is being read
   assign pkt_ready = !rsp_valid_ff || rsp_ch.ready;
   assign take      = pkt_valid && pkt_ready;

   // Delta scaling and move
   always_comb begin
      dx_s  = scale_delta(pkt.dx, pkt.status[ST_XSIGN]);
      dy_s  = scale_delta(pkt.dy, pkt.status[ST_YSIGN]);
      sum_x = $signed(SUM_W'(pos_x_ff)) + SUM_W'(dx_s);
      sum_y = $signed(SUM_W'(pos_y_ff)) - SUM_W'(dy_s);
   end

   // Buttons and attribute
   always_comb begin
      btn_l = pkt.status[ST_LEFT];
      btn_r = pkt.status[ST_RIGHT];
      btn_m = pkt.status[ST_MIDDLE];
      attr  = ATTR_BASE - (btn_l ? ATTR_LEFT : '0) - (btn_r ? ATTR_RIGHT : '0)
            - (btn_m ? ATTR_MIDDLE : '0);
   end

   // Clamp into the screen
   always_comb begin
      pos_x_in     = take ? clamp_axis(sum_x, screen_width) : pos_x_ff;
      pos_y_in     = take ? clamp_axis(sum_y, screen_height) : pos_y_ff;
      rsp_valid_in = take || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         cur_x_ff <= COORD_W'(pos_x_in);
         cur_y_ff <= COORD_W'(pos_y_in);
         old_x_ff <= COORD_W'(pos_x_ff);
         old_y_ff <= COORD_W'(pos_y_ff);
         btn_l_ff <= btn_l;
         btn_r_ff <= btn_r;
         btn_m_ff <= btn_m;
         attr_ff  <= attr;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cursor_x      = cur_x_ff;
   assign rsp_ch.cursor_y      = cur_y_ff;
   assign rsp_ch.old_x         = old_x_ff;
   assign rsp_ch.old_y         = old_y_ff;
   assign rsp_ch.button_left   = btn_l_ff;
   assign rsp_ch.button_right  = btn_r_ff;
   assign rsp_ch.button_middle = btn_m_ff;
   assign rsp_ch.cursor_attr   = attr_ff;

endmodule

[src/ps2_mouse_packet_tracker_top.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top: PS/2 mouse packet tracker
// Groups mouse bytes into three-byte packets and tracks a clamped cursor.
//
// Usage:
//   req_ch  - one mouse byte per word. Bytes are framed status, X, Y in turn.
//   rsp_ch  - one cursor update word per completed packet: new and old
//             position, the three buttons and the cursor attribute.
//   csr_ch  - register writes: index 0 screen width, index 1 screen height.
//             Always ready; write only while the tracker is idle.
// Path: the third byte of a packet is registered in the packet register, then
//   the update word is registered in the result register.
// Throughput: one byte per cycle while req_ch.ready stays high.
// Stalls: a held result blocks nothing until a second packet also completes;
//   req_ch.ready drops only while both the packet and result registers are
//   full and rsp_ch.ready is low. No word is dropped or repeated.
// Reset: phase back to the status byte, position 0,0, width 80, height 25,
//   no result pending.
// -----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top (
   input  logic         clock,
   input  logic         reset,
   ps2mpt_req_if.sink   req_ch,
   ps2mpt_rsp_if.source rsp_ch,
   ps2mpt_csr_if.sink   csr_ch
);
   import ps2mpt_pkg::*;

   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic                  csr_write;
   logic                  pkt_valid;
   logic                  pkt_ready;
   pkt_type               pkt;

   // Screen size registers
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_ch.index)
            CSR_SCREEN_WIDTH:  width_in  = csr_ch.data;
            CSR_SCREEN_HEIGHT: height_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RST;
         height_ff <= SCREEN_HEIGHT_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Packet framing
   ps2mpt_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .pkt_valid (pkt_valid),
      .pkt       (pkt),
      .pkt_ready (pkt_ready)
   );

   // Position update and result
   ps2mpt_update u_update (
      .clock         (clock),
      .reset         (reset),
      .pkt_valid     (pkt_valid),
      .pkt           (pkt),
      .pkt_ready     (pkt_ready),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .rsp_ch        (rsp_ch)
   );

endmodule

[tb/ps2_mouse_packet_tracker_top_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top_tb: self-checking bench for the packet tracker
// Streams mouse bytes into the tracker, keeps its own model of the packet
// framing, delta scaling and clamped cursor, and checks every cursor update
// word against it. Covers default and extreme screen sizes, shrinking the
// screen under the cursor, spare register indexes, output backpressure and
// randomized byte streams with random idle cycles on both channels.
// -----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top_tb;
   import ps2mpt_pkg::*;

   // Register indexes the tracker does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_HI = '1;

   localparam int IDLE_PCT    = 36;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE_CYC  = 4;

   // One expected cursor update
   typedef struct packed {
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic [COORD_W-1:0] old_x;
      logic [COORD_W-1:0] old_y;
      logic               button_left;
      logic               button_right;
      logic               button_middle;
      logic [ATTR_W-1:0]  cursor_attr;
   } cursor_move_type;

   logic clock = 1'b0;
   logic reset;

   ps2mpt_req_if req_ch ();
   ps2mpt_rsp_if rsp_ch ();
   ps2mpt_csr_if csr_ch ();

   ps2_mouse_packet_tracker_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Tracker model state
   phase_type               trk_phase;
   logic [BYTE_W-1:0]       trk_status;
   logic [BYTE_W-1:0]       trk_dx;
   logic [POS_BITS-1:0]     trk_x;
   logic [POS_BITS-1:0]     trk_y;
   logic [CSR_DATA_W-1:0]   scr_width;
   logic [CSR_DATA_W-1:0]   scr_height;

   cursor_move_type pending_moves[$];
   int              mismatch_count = 0;

   // Traffic shaping
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   int rx_hold   = 0;

   // Clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Delta byte with separate sign bit, divided by 6 toward zero
   function automatic int tick_delta(input logic [BYTE_W-1:0] lo, input logic sgn);
      int v;
      v = int'(lo) - (sgn ? 256 : 0);
      return v / 6;
   endfunction

   // Clamp to [0, size-1]; size zero pins to 0
   function automatic logic [POS_BITS-1:0] fit_axis(input longint v,
                                                    input logic [CSR_DATA_W-1:0] size);
      longint r;
      r = v;
      if (r >= longint'(size)) r = longint'(size) - 1;
      if (r < 0) r = 0;
      return POS_BITS'(r);
   endfunction

   // Advance the model by one accepted byte
   task automatic track_byte(input logic [BYTE_W-1:0] b);
      cursor_move_type mv;
      longint          nx;
      longint          ny;
      case (trk_phase)
         PH_DX: begin
            trk_dx    = b;
            trk_phase = PH_DY;
         end
         PH_DY: begin
            nx = longint'(trk_x) + tick_delta(trk_dx, trk_status[ST_XSIGN]);
            ny = longint'(trk_y) - tick_delta(b, trk_status[ST_YSIGN]);
            mv.old_x         = COORD_W'(trk_x);
            mv.old_y         = COORD_W'(trk_y);
            mv.button_left   = trk_status[ST_LEFT];
            mv.button_right  = trk_status[ST_RIGHT];
            mv.button_middle = trk_status[ST_MIDDLE];
            mv.cursor_attr   = ATTR_BASE
                               - (mv.button_left   ? ATTR_LEFT   : '0)
                               - (mv.button_right  ? ATTR_RIGHT  : '0)
                               - (mv.button_middle ? ATTR_MIDDLE : '0);
            trk_x = fit_axis(nx, scr_width);
            trk_y = fit_axis(ny, scr_height);
            mv.cursor_x = COORD_W'(trk_x);
            mv.cursor_y = COORD_W'(trk_y);
            pending_moves.push_back(mv);
            trk_phase = PH_STATUS;
         end
         default: begin
            // status byte; an unused phase code also lands here
            trk_status = b;
            trk_phase  = PH_DX;
         end
      endcase
   endtask

   // Offer one byte, with random idle cycles ahead of it unless tx_steady is set
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      @(negedge clock);
      if (!tx_steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      track_byte(b);
   endtask

   task automatic send_packet(input logic [BYTE_W-1:0] st,
                              input logic [BYTE_W-1:0] dx,
                              input logic [BYTE_W-1:0] dy);
      send_byte(st);
      send_byte(dx);
      send_byte(dy);
   endtask

   // Stop offering, wait for every expected word, then let the pipe settle
   task automatic wait_drain();
      int n;
      n = 0;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_moves.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Register write; only called while the tracker is idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_SCREEN_WIDTH:  scr_width  = val;
         CSR_SCREEN_HEIGHT: scr_height = val;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Result side ready: random stalls, steady stretches and long hold-offs
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold--;
         end else if (rx_steady) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Compare each accepted update word with the oldest expectation
   always @(posedge clock) begin
      cursor_move_type exp_mv;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_moves.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected update word: x=%0d y=%0d", rsp_ch.cursor_x,
                        rsp_ch.cursor_y);
            mismatch_count++;
         end else begin
            exp_mv = pending_moves.pop_front();
            if (rsp_ch.cursor_x      !== exp_mv.cursor_x      ||
                rsp_ch.cursor_y      !== exp_mv.cursor_y      ||
                rsp_ch.old_x         !== exp_mv.old_x         ||
                rsp_ch.old_y         !== exp_mv.old_y         ||
                rsp_ch.button_left   !== exp_mv.button_left   ||
                rsp_ch.button_right  !== exp_mv.button_right  ||
                rsp_ch.button_middle !== exp_mv.button_middle ||
                rsp_ch.cursor_attr   !== exp_mv.cursor_attr) begin
               if (mismatch_count < 10) begin
                  $display("mismatch exp: x=%0d y=%0d ox=%0d oy=%0d lrm=%b%b%b attr=%h",
                           exp_mv.cursor_x, exp_mv.cursor_y, exp_mv.old_x, exp_mv.old_y,
                           exp_mv.button_left, exp_mv.button_right,
                           exp_mv.button_middle, exp_mv.cursor_attr);
                  $display("         got: x=%0d y=%0d ox=%0d oy=%0d lrm=%b%b%b attr=%h",
                           rsp_ch.cursor_x, rsp_ch.cursor_y, rsp_ch.old_x, rsp_ch.old_y,
                           rsp_ch.button_left, rsp_ch.button_right,
                           rsp_ch.button_middle, rsp_ch.cursor_attr);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Buttons, attribute and delta extremes at the reset screen size
   task automatic test_reset_defaults();
      send_packet(8'h01, 8'hFF, 8'h00);   // left, largest right move
      send_packet(8'h12, 8'h80, 8'hFF);   // right, XS set, Y clamps at 0
      send_packet(8'h24, 8'h00, 8'h00);   // middle, largest down move, Y clamps
      send_packet(8'hCF, 8'h7F, 8'h80);   // overflow bits and bit 3, all buttons
      send_packet(8'h30, 8'hFF, 8'hFF);   // -1 on both axes scales to zero
      send_packet(8'h10, 8'h00, 8'h01);   // largest left move, X back to 0
      wait_drain();
   endtask

   // Size zero, full size, shrinking under the cursor, spare indexes
   task automatic test_screen_size();
      write_csr(CSR_SCREEN_WIDTH, 16'h0000);
      write_csr(CSR_SCREEN_HEIGHT, 16'h0000);
      send_packet(8'h20, 8'hFF, 8'h00);
      wait_drain();
      write_csr(CSR_SCREEN_WIDTH, 16'hFFFF);
      write_csr(CSR_SCREEN_HEIGHT, 16'hFFFF);
      send_packet(8'h20, 8'hFF, 8'h00);
      send_packet(8'h20, 8'hFF, 8'h00);
      wait_drain();
      // cursor now beyond the new size; next packet pulls it in
      write_csr(CSR_SCREEN_WIDTH, 16'd10);
      write_csr(CSR_SCREEN_HEIGHT, 16'd5);
      write_csr(CSR_IDX_SPARE_LO, 16'h0000);
      write_csr(CSR_IDX_SPARE_HI, 16'hFFFF);
      send_packet(8'h00, 8'h00, 8'h00);
      wait_drain();
   endtask

   // Hold off the result side long enough to stall the byte input
   task automatic test_backpressure();
      write_csr(CSR_SCREEN_WIDTH, 16'd200);
      write_csr(CSR_SCREEN_HEIGHT, 16'd150);
      rx_hold   = 300;
      tx_steady = 1'b1;
      repeat (30)
         send_packet(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
      tx_steady = 1'b0;
      wait_drain();
   endtask

   // One random phase at a given screen size
   task automatic run_phase(input logic [CSR_DATA_W-1:0] w,
                            input logic [CSR_DATA_W-1:0] h,
                            input int pkts, input bit drift);
      logic [BYTE_W-1:0] st;
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
      repeat (pkts) begin
         st = 8'($urandom_range(255));
         // drift toward the far corner so large screens get deep positions
         if (drift && $urandom_range(99) < 80) begin
            st[ST_XSIGN] = 1'b0;
            st[ST_YSIGN] = 1'b1;
         end
         send_packet(st, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      wait_drain();
   endtask

   task automatic test_random_traffic();
      run_phase(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 84, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 84, 1'b1);
      // no idling on either side here
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      run_phase(16'd1, 16'hFFFF, 84, 1'b0);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      run_phase(16'($urandom_range(300, 1)), 16'($urandom_range(300, 1)), 84, 1'b0);
      run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)), 84, 1'b1);
      run_phase(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)), 84, 1'b0);
   endtask

   // Main sequence
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      trk_phase      = PH_STATUS;
      trk_status     = '0;
      trk_dx         = '0;
      trk_x          = '0;
      trk_y          = '0;
      scr_width      = SCREEN_WIDTH_RST;
      scr_height     = SCREEN_HEIGHT_RST;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_screen_size();
      test_backpressure();
      test_random_traffic();

      wait_drain();
      repeat (8) @(posedge clock);
      if (pending_moves.size() != 0) begin
         if (mismatch_count < 10)
            $display("%0d expected update words never arrived", pending_moves.size());
         mismatch_count += pending_moves.size();
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
